// ===== design/ewh_pkg.sv =====
package ewh_pkg;

	// Item kinds
	typedef enum logic [1:0] {
		KIND_INSERT     = 2'd0,
		KIND_READ_BIN   = 2'd1,
		KIND_READ_TOTAL = 2'd2
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_DROPPED   = 2'd1,
		STATUS_BAD_INDEX = 2'd2
	} status_t;

	// Configuration register indexes
	localparam int unsigned  CFG_IDX_W        = 2;
	localparam logic [1:0]   REG_RANGE_LOW    = 2'd0;
	localparam logic [1:0]   REG_RANGE_HIGH   = 2'd1;
	localparam logic [1:0]   REG_BINS_IN_USE  = 2'd2;

	// Fixed field widths
	localparam int unsigned  BINS_REG_W       = 11;
	localparam int unsigned  BIN_PORT_W       = 10;

	// Register reset values
	localparam int unsigned  RANGE_HIGH_RESET = 65536;
	localparam logic [10:0]  BINS_RESET       = 11'd1024;

endpackage

// ===== design/ewh_div.sv =====
module ewh_div #(
	parameter int unsigned DEN_W  = 32,
	parameter int unsigned QUOT_W = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DEN_W-1:0]  num_hi,
	input  logic [QUOT_W-1:0] num_lo,
	input  logic [DEN_W-1:0]  den,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUOT_W-1:0] lo_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;

	logic [DEN_W:0]    trial;
	logic              take;
	logic [DEN_W:0]    diff;

	// One quotient bit per cycle: shift in the next numerator bit, subtract if it fits
	assign trial = {rem_q, lo_q[QUOT_W-1]};
	assign take  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(QUOT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num_hi;
			lo_q   <= num_lo;
			den_q  <= den;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			lo_q   <= lo_q << 1;
			quot_q <= (quot_q << 1) | QUOT_W'(take);
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q)
		else $error("divider started while running");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> rem_q < den_q)
		else $error("partial remainder not below divisor");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q && $past(run_q))
		else $error("done without a finished run");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held longer than one cycle");

endmodule

// ===== design/equal_width_histogram_core.sv =====
// Equal-width histogram over [range_low, range_high] (signed Q16.16, swapped when reversed).
// After reset the bin memory is cleared one entry per cycle, and busy stays high until all
// NUM_BINS entries (1024 by default) are cleared and only then is the first item taken;
// configuration writes are taken at any time but must only be issued while busy is low.
// Items are taken when start is high and busy is low, one at a time. Each item gives exactly
// one result, shown for one cycle with done high; the receiver cannot stall it. A total read,
// an unused kind, an out-of-range insert or a bad index gives its result straight from the
// prep state; a bin read and an insert at the upper bound or into a zero-width range pass
// through the read and update states; any other insert first passes the multiply and divide
// states, with the divider forming one bin-index bit per cycle. busy drops in the cycle the
// result is shown, so the next item may follow.
module equal_width_histogram_core
	import ewh_pkg::*;
#(
	parameter int unsigned NUM_BINS    = 1024,
	parameter int unsigned VALUE_WIDTH = 32,
	parameter int unsigned COUNT_WIDTH = 32,
	localparam int unsigned CFG_W      = (VALUE_WIDTH > BINS_REG_W) ? VALUE_WIDTH : BINS_REG_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             kind,
	input  logic [VALUE_WIDTH-1:0] sample,
	input  logic [BIN_PORT_W-1:0]  bin_index,
	output logic                   done,
	output logic [COUNT_WIDTH-1:0] count,
	output logic [1:0]             status,
	output logic [BIN_PORT_W-1:0]  bin_hit,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int unsigned VW = VALUE_WIDTH;
	localparam int unsigned CW = COUNT_WIDTH;
	localparam int unsigned BW = $clog2(NUM_BINS + 1);
	localparam int unsigned IW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int unsigned XW = (BW > BINS_REG_W) ? BW : BINS_REG_W;
	localparam int unsigned PW = VW + BW;
	localparam logic [IW-1:0] LAST_BIN = IW'(NUM_BINS - 1);
	localparam logic [XW-1:0] MAX_BINS = XW'(NUM_BINS);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_PREP   = 7'b0000100,
		ST_MUL    = 7'b0001000,
		ST_DIV    = 7'b0010000,
		ST_READ   = 7'b0100000,
		ST_UPDATE = 7'b1000000
	} state_t;

	state_t                state_q;
	logic [IW-1:0]         clr_q;
	logic [CW-1:0]         total_q;
	logic                  done_q;
	logic [VW-1:0]         range_low_q;
	logic [VW-1:0]         range_high_q;
	logic [BINS_REG_W-1:0] bins_q;

	kind_t                 kind_q;
	logic [VW-1:0]         sample_q;
	logic [BIN_PORT_W-1:0] index_q;
	logic [VW-1:0]         off_q;
	logic [VW-1:0]         span_q;
	logic [IW-1:0]         bin_q;
	logic [CW-1:0]         count_q;
	status_t               status_q;
	logic [BIN_PORT_W-1:0] hit_q;

	logic [CW-1:0]         bin_mem [NUM_BINS];
	logic [CW-1:0]         rdata_q;
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	logic [CW-1:0]         mem_wdata;
	logic                  mem_re;

	logic [VW-1:0]         lo_raw, hi_raw, lo_o, hi_o, v_o;
	logic                  in_range;
	logic [XW-1:0]         bins_x, idx_x, eff_x, hit_x;
	logic [BW-1:0]         eff, eff_m1;
	logic [PW-1:0]         prod;
	logic                  div_start, div_done;
	logic [BW-1:0]         div_quot;
	logic                  insert_upd;

	// Bounds and sample in offset binary so plain unsigned compares keep signed order
	assign lo_raw   = {~range_low_q[VW-1], range_low_q[VW-2:0]};
	assign hi_raw   = {~range_high_q[VW-1], range_high_q[VW-2:0]};
	assign v_o      = {~sample_q[VW-1], sample_q[VW-2:0]};
	assign lo_o     = (lo_raw > hi_raw) ? hi_raw : lo_raw;
	assign hi_o     = (lo_raw > hi_raw) ? lo_raw : hi_raw;
	assign in_range = (v_o >= lo_o) && (v_o <= hi_o);

	// Bins in use, zero acting as one and clamped to the memory depth
	assign bins_x = XW'(bins_q);
	always_comb begin
		if (bins_q == '0) begin
			eff_x = XW'(1);
		end else if (bins_x > MAX_BINS) begin
			eff_x = MAX_BINS;
		end else begin
			eff_x = bins_x;
		end
	end
	assign eff    = eff_x[BW-1:0];
	assign eff_m1 = eff - BW'(1);
	assign idx_x  = XW'(index_q);
	assign hit_x  = XW'(bin_q);

	// Offset is below span here, so the high part of the product is below span too
	assign prod      = PW'(off_q) * PW'(eff);
	assign div_start = (state_q == ST_MUL);

	ewh_div #(
		.DEN_W  (VW),
		.QUOT_W (BW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_hi (prod[PW-1:BW]),
		.num_lo (prod[BW-1:0]),
		.den    (span_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign insert_upd = (state_q == ST_UPDATE) && (kind_q == KIND_INSERT);
	assign mem_re     = (state_q == ST_READ);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = bin_q;
		mem_wdata = (rdata_q == '1) ? rdata_q : rdata_q + CW'(1);
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (insert_upd) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= bin_mem[bin_q];
		end
	end

	// Control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			total_q      <= '0;
			done_q       <= 1'b0;
			range_low_q  <= '0;
			range_high_q <= VW'(RANGE_HIGH_RESET);
			bins_q       <= BINS_RESET;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RANGE_LOW:   range_low_q  <= cfg_data[VW-1:0];
					REG_RANGE_HIGH:  range_high_q <= cfg_data[VW-1:0];
					REG_BINS_IN_USE: bins_q       <= cfg_data[BINS_REG_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == LAST_BIN) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					case (kind_q)
						KIND_INSERT: begin
							if (!in_range) begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else if (hi_o == lo_o || v_o == hi_o) begin
								state_q <= ST_READ;
							end else begin
								state_q <= ST_MUL;
							end
						end
						KIND_READ_BIN: begin
							if (idx_x >= eff_x) begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_READ;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (kind_q == KIND_INSERT) begin
						total_q <= (total_q == '1) ? total_q : total_q + CW'(1);
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					kind_q   <= kind_t'(kind);
					sample_q <= sample;
					index_q  <= bin_index;
				end
			end
			ST_PREP: begin
				off_q  <= v_o - lo_o;
				span_q <= hi_o - lo_o;
				if (kind_q == KIND_INSERT) begin
					bin_q <= (hi_o == lo_o) ? '0 : eff_m1[IW-1:0];
				end else begin
					bin_q <= idx_x[IW-1:0];
				end
				count_q  <= '0;
				status_q <= STATUS_OK;
				hit_q    <= '0;
				case (kind_q)
					KIND_INSERT: begin
						if (!in_range) begin
							status_q <= STATUS_DROPPED;
						end
					end
					KIND_READ_BIN: begin
						if (idx_x >= eff_x) begin
							status_q <= STATUS_BAD_INDEX;
						end
					end
					KIND_READ_TOTAL: begin
						count_q <= total_q;
					end
					default: ;
				endcase
			end
			ST_DIV: begin
				if (div_done) begin
					bin_q <= div_quot[IW-1:0];
				end
			end
			ST_UPDATE: begin
				status_q <= STATUS_OK;
				if (kind_q == KIND_INSERT) begin
					count_q <= '0;
					hit_q   <= hit_x[BIN_PORT_W-1:0];
				end else begin
					count_q <= rdata_q;
					hit_q   <= '0;
				end
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign count     = count_q;
	assign status    = status_q;
	assign bin_hit   = hit_q;

	a_done_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result shown while an item is still in work");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_insert_result: assert property (@(posedge clk) disable iff (!arst_n)
		insert_upd |=> done_q && status == STATUS_OK && count == '0)
		else $error("counted insert did not give an ok result");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_CLEAR |=> total_q >= $past(total_q))
		else $error("total count went down");

endmodule
